// ===== sv/gadget_matrix_vector_multiply_mod_macros.svh =====
// assertion macros for the rtl files, used by gmv_back
`ifndef GADGET_MATRIX_VECTOR_MULTIPLY_MOD_MACROS_SVH
`define GADGET_MATRIX_VECTOR_MULTIPLY_MOD_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define GMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define GMV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GMV_ASSERT(lbl, prop, msg)
`define GMV_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/gmv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gmv_pkg;

  // bounds on the gadget shape
  localparam int MAX_FACTORS = 4;
  localparam int MAX_USES    = 64;
  localparam int MAX_ROWS    = 1024;

  // field widths
  localparam int DATA_W        = 32;
  localparam int NUM_ROWS_W    = 11;
  localparam int NUM_FACTORS_W = 3;
  localparam int NUM_USES_W    = 7;

  // counter widths
  localparam int FACT_W = $clog2(MAX_FACTORS);
  localparam int USE_W  = $clog2(MAX_USES);
  localparam int ROW_W  = $clog2(MAX_ROWS);

  // modular datapath: residues up to 2^32 plus headroom for doubling
  localparam int ACC_W  = DATA_W + 2;
  localparam int STEP_W = $clog2(DATA_W);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register map
  localparam int NUM_REGS = 8;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 2;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_MODULUS,
    REG_NUM_ROWS,
    REG_NUM_FACTORS,
    REG_USES_PER_FACTOR,
    REG_FACTOR_A,
    REG_FACTOR_B,
    REG_FACTOR_C,
    REG_FACTOR_D
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0]        modulus;
    logic [NUM_ROWS_W-1:0]    num_rows;
    logic [NUM_FACTORS_W-1:0] num_factors;
    logic [NUM_USES_W-1:0]    uses_per_factor;
    logic [DATA_W-1:0]        factor_a;
    logic [DATA_W-1:0]        factor_b;
    logic [DATA_W-1:0]        factor_c;
    logic [DATA_W-1:0]        factor_d;
  } cfg_t;

  // one classified item as the front hands it to the back
  typedef struct packed {
    logic [DATA_W-1:0] mag;
    logic              neg;
    logic [FACT_W-1:0] factor_sel;
    logic              row_end;
    logic [ROW_W-1:0]  row_index;
    logic              last_row;
  } work_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REDUCE,
    BK_MUL,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/gmv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gmv_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gmv_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gmv_pkg::DATA_W-1:0]     x_value,
  input  logic                                  queue_full,
  output logic                                  push,
  output gmv_pkg::work_item_t                   push_item
);
  import gmv_pkg::*;

  logic [USE_W-1:0]         use_position;
  logic [FACT_W-1:0]        factor_position;
  logic [ROW_W-1:0]         row_position;
  logic [NUM_USES_W-1:0]    e_eff;
  logic [NUM_FACTORS_W-1:0] k_eff;
  logic [NUM_ROWS_W-1:0]    n_eff;
  logic [NUM_USES_W-1:0]    use_inc;
  logic [NUM_FACTORS_W-1:0] fact_inc;
  logic [NUM_ROWS_W-1:0]    row_inc;
  logic                     use_wrap;
  logic                     fact_wrap;
  logic                     last;
  logic [DATA_W-1:0]        x_raw;

  // zero counts act as one, large counts saturate
  always_comb begin
    if (cfg.uses_per_factor == '0) e_eff = NUM_USES_W'(1);
    else if (cfg.uses_per_factor > NUM_USES_W'(MAX_USES)) e_eff = NUM_USES_W'(MAX_USES);
    else e_eff = cfg.uses_per_factor;
    if (cfg.num_factors == '0) k_eff = NUM_FACTORS_W'(1);
    else if (cfg.num_factors > NUM_FACTORS_W'(MAX_FACTORS)) k_eff = NUM_FACTORS_W'(MAX_FACTORS);
    else k_eff = cfg.num_factors;
    if (cfg.num_rows == '0) n_eff = NUM_ROWS_W'(1);
    else if (cfg.num_rows > NUM_ROWS_W'(MAX_ROWS)) n_eff = NUM_ROWS_W'(MAX_ROWS);
    else n_eff = cfg.num_rows;
  end

  // position bookkeeping, compared with >= so a shrunk bound ends at once
  assign use_inc   = NUM_USES_W'(use_position) + NUM_USES_W'(1);
  assign fact_inc  = NUM_FACTORS_W'(factor_position) + NUM_FACTORS_W'(1);
  assign row_inc   = NUM_ROWS_W'(row_position) + NUM_ROWS_W'(1);
  assign use_wrap  = use_inc >= e_eff;
  assign fact_wrap = fact_inc >= k_eff;
  assign last      = row_inc >= n_eff;

  // handshake into the queue
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // sign and magnitude of the element
  assign x_raw = DATA_W'(x_value);

  always_comb begin
    push_item.neg        = x_raw[DATA_W-1];
    push_item.mag        = x_raw[DATA_W-1] ? (DATA_W'(0) - x_raw) : x_raw;
    push_item.factor_sel = factor_position;
    push_item.row_end    = use_wrap && fact_wrap;
    push_item.row_index  = row_position;
    push_item.last_row   = last;
  end

  // advance use, factor and row positions per item
  always_ff @(posedge clk) begin
    if (rst) begin
      use_position    <= '0;
      factor_position <= '0;
      row_position    <= '0;
    end else if (push) begin
      if (!use_wrap) begin
        use_position <= use_inc[USE_W-1:0];
      end else begin
        use_position <= '0;
        if (!fact_wrap) begin
          factor_position <= fact_inc[FACT_W-1:0];
        end else begin
          factor_position <= '0;
          row_position    <= last ? '0 : row_inc[ROW_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/gmv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gmv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gmv_pkg::work_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output gmv_pkg::work_item_t head
);
  import gmv_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

// ===== sv/gmv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "gadget_matrix_vector_multiply_mod_macros.svh"
module gmv_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gmv_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  gmv_pkg::work_item_t           q_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gmv_pkg::DATA_W-1:0]    y_value,
  output logic [gmv_pkg::ROW_W-1:0]     row_index,
  output logic                          last_row
);
  import gmv_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  back_state_t       state;
  back_state_t       state_next;
  logic [STEP_W-1:0] step;
  work_item_t        item;
  logic [DATA_W-1:0] row_sum;
  logic [DATA_W-1:0] gadget_power;
  logic [ACC_W-1:0]  acc0;
  logic [ACC_W-1:0]  acc1;
  logic [ACC_W-1:0]  a_op;
  logic [DATA_W-1:0] b0;
  logic [DATA_W-1:0] b1;
  logic [ACC_W-1:0]  qe;
  logic [ACC_W-1:0]  lane0;
  logic [ACC_W-1:0]  lane1;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  sum_raw;
  logic [ACC_W-1:0]  sum_mod;
  logic              need_reduce;
  logic              out_free;
  logic              run;
  logic              reduce_done;
  logic              finish_ok;
  logic              emit;

  // one shift-add step of a modular product, acc and a below q
  function automatic logic [ACC_W-1:0] mm_step(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] q,
                                               input logic             b_bit);
    logic [ACC_W-1:0] t;
    t = acc << 1;
    if (t >= q) t = t - q;
    if (b_bit) t = t + a;
    if (t >= q) t = t - q;
    return t;
  endfunction

  function automatic logic [DATA_W-1:0] factor_of(input cfg_t c, input logic [FACT_W-1:0] sel);
    logic [DATA_W-1:0] f;
    case (sel)
      2'd0:    f = c.factor_a;
      2'd1:    f = c.factor_b;
      2'd2:    f = c.factor_c;
      2'd3:    f = c.factor_d;
      default: f = c.factor_a;
    endcase
    return f;
  endfunction

  // modulus zero stands for 2^32
  assign qe = (cfg.modulus == '0) ? (ACC_W'(1) << DATA_W) : ACC_W'(cfg.modulus);

  // stored sum or power at or above q after a modulus change
  assign need_reduce = (ACC_W'(gadget_power) >= qe) || (ACC_W'(row_sum) >= qe);
  assign out_free    = !out_valid || out_ready;

  // two lanes share the multiplicand and modulus
  assign lane0 = mm_step(acc0, a_op, qe, b0[DATA_W-1]);
  assign lane1 = mm_step(acc1, a_op, qe, b1[DATA_W-1]);

  // signed fix-up of the term and the running sum
  assign term    = (item.neg && acc0 != '0) ? (qe - acc0) : acc0;
  assign sum_raw = ACC_W'(row_sum) + term;
  assign sum_mod = (sum_raw >= qe) ? (sum_raw - qe) : sum_raw;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = need_reduce ? BK_REDUCE : BK_MUL;
      end
      BK_REDUCE: begin
        if (step == STEP_LAST) state_next = BK_MUL;
      end
      BK_MUL: begin
        if (step == STEP_LAST) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!item.row_end || out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    pop         = 1'b0;
    run         = 1'b0;
    reduce_done = 1'b0;
    finish_ok   = 1'b0;
    case (state)
      BK_IDLE:   pop = !q_empty;
      BK_REDUCE: begin
        run         = 1'b1;
        reduce_done = step == STEP_LAST;
      end
      BK_MUL:    run = 1'b1;
      BK_DONE:   finish_ok = !item.row_end || out_free;
      default:   pop = 1'b0;
    endcase
    emit = finish_ok && item.row_end;
  end

  // control state, model state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      row_sum      <= '0;
      gadget_power <= DATA_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (reduce_done) begin
        gadget_power <= lane0[DATA_W-1:0];
        row_sum      <= lane1[DATA_W-1:0];
      end else if (finish_ok) begin
        if (item.row_end) begin
          row_sum      <= '0;
          gadget_power <= DATA_W'(1);
        end else begin
          row_sum      <= sum_mod[DATA_W-1:0];
          gadget_power <= acc1[DATA_W-1:0];
        end
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q_item;
      acc0 <= '0;
      acc1 <= '0;
      step <= '0;
      if (need_reduce) begin
        a_op <= ACC_W'(1);
        b0   <= gadget_power;
        b1   <= row_sum;
      end else begin
        a_op <= ACC_W'(gadget_power);
        b0   <= q_item.mag;
        b1   <= factor_of(cfg, q_item.factor_sel);
      end
    end else if (run) begin
      step <= step + STEP_W'(1);
      if (reduce_done) begin
        a_op <= lane0;
        b0   <= item.mag;
        b1   <= factor_of(cfg, item.factor_sel);
        acc0 <= '0;
        acc1 <= '0;
      end else begin
        b0   <= b0 << 1;
        b1   <= b1 << 1;
        acc0 <= lane0;
        acc1 <= lane1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      y_value   <= sum_mod[DATA_W-1:0];
      row_index <= item.row_index;
      last_row  <= item.last_row;
    end
  end

  `GMV_ASSERT(a_emit_from_done, $rose(out_valid) |-> $past(state == BK_DONE), "result not from done")
  `GMV_ASSERT(a_mul_ends, (state == BK_MUL && step == STEP_LAST) |=> (state == BK_DONE), "multiply overran")
  `GMV_ASSERT_NEVER(a_reduce_skipped, state == BK_MUL && $past(state == BK_IDLE) && $past(need_reduce), "reduction skipped")

endmodule
`default_nettype wire

// ===== sv/gadget_matrix_vector_multiply_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                                               | dir | moves
// ----------+-------------------------------------------------------+-----+-----------------------
// input     | in_valid, in_ready, x_value                           | in  | one element of x per item
// output    | out_valid, out_ready, y_value, row_index, last_row    | out | one row sum per item
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready  | i/o | register writes and reads
//
// an element runs through the back end in order: a load, 32 shift-add steps of the
// two-lane modular multiplier (term and next power), and an add into the row sum.
// after a modulus change leaves the stored sum or power at or above q, the next element
// first runs a 32-step reduction pass on the same lanes. a two-entry queue lets the front
// take items while the back works; the result register lets the back go on while a row
// sum waits. reset is synchronous, active high.
module gadget_matrix_vector_multiply_mod (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gmv_pkg::PADDR_W-1:0]        paddr,
  input  logic [gmv_pkg::DATA_W-1:0]         pwdata,
  output logic [gmv_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gmv_pkg::DATA_W-1:0]  x_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gmv_pkg::DATA_W-1:0]         y_value,
  output logic [gmv_pkg::ROW_W-1:0]          row_index,
  output logic                               last_row
);
  import gmv_pkg::*;

  cfg_t       cfg;
  reg_idx_t   reg_idx;
  logic       wr_en;
  logic       queue_full;
  logic       queue_empty;
  logic       push;
  logic       pop;
  work_item_t push_item;
  work_item_t head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus         <= DATA_W'(65537);
      cfg.num_rows        <= NUM_ROWS_W'(1);
      cfg.num_factors     <= NUM_FACTORS_W'(1);
      cfg.uses_per_factor <= NUM_USES_W'(8);
      cfg.factor_a        <= DATA_W'(2);
      cfg.factor_b        <= DATA_W'(2);
      cfg.factor_c        <= DATA_W'(2);
      cfg.factor_d        <= DATA_W'(2);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODULUS:         cfg.modulus         <= pwdata;
        REG_NUM_ROWS:        cfg.num_rows        <= pwdata[NUM_ROWS_W-1:0];
        REG_NUM_FACTORS:     cfg.num_factors     <= pwdata[NUM_FACTORS_W-1:0];
        REG_USES_PER_FACTOR: cfg.uses_per_factor <= pwdata[NUM_USES_W-1:0];
        REG_FACTOR_A:        cfg.factor_a        <= pwdata;
        REG_FACTOR_B:        cfg.factor_b        <= pwdata;
        REG_FACTOR_C:        cfg.factor_c        <= pwdata;
        REG_FACTOR_D:        cfg.factor_d        <= pwdata;
        default:             cfg.modulus         <= cfg.modulus;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_MODULUS:         prdata = cfg.modulus;
      REG_NUM_ROWS:        prdata = DATA_W'(cfg.num_rows);
      REG_NUM_FACTORS:     prdata = DATA_W'(cfg.num_factors);
      REG_USES_PER_FACTOR: prdata = DATA_W'(cfg.uses_per_factor);
      REG_FACTOR_A:        prdata = cfg.factor_a;
      REG_FACTOR_B:        prdata = cfg.factor_b;
      REG_FACTOR_C:        prdata = cfg.factor_c;
      REG_FACTOR_D:        prdata = cfg.factor_d;
      default:             prdata = '0;
    endcase
  end

  // front: accept and classify
  gmv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_value    (x_value),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // queue between front and back
  gmv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  // back: modular arithmetic and result register
  gmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (queue_empty),
    .q_item    (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .y_value   (y_value),
    .row_index (row_index),
    .last_row  (last_row)
  );

endmodule
`default_nettype wire
